// ===== src/wrapped_convolution_3x3_rgb_macros.svh =====
// Assertion macros for the 3x3 RGB convolution block.
// Used by the modules in src; expects clk and rst_n in scope.
`ifndef WRAPPED_CONVOLUTION_3X3_RGB_MACROS_SVH
`define WRAPPED_CONVOLUTION_3X3_RGB_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WCV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define WCV_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define WCV_ASSERT(lbl, prop, msg)
`define WCV_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== src/wcv_pkg.sv =====
// Shared types, constants and helpers for the 3x3 RGB convolution block.
// No dependencies.
package wcv_pkg;

  localparam int MAX_LINE_LENGTH_DEF = 4096;
  localparam int MAX_LINE_COUNT_DEF  = 4096;
  localparam int JOB_COL_W           = 14;
  localparam int REG_W               = 48;
  localparam int IDX_W               = 3;
  localparam int SIZE_W              = 13;
  localparam int MIN_SIZE            = 3;

  localparam logic [IDX_W-1:0] REG_LINE_LENGTH = 3'd0;
  localparam logic [IDX_W-1:0] REG_LINE_COUNT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEFF_PREV  = 3'd2;
  localparam logic [IDX_W-1:0] REG_COEFF_SAME  = 3'd3;
  localparam logic [IDX_W-1:0] REG_COEFF_NEXT  = 3'd4;
  localparam logic [IDX_W-1:0] REG_GAIN        = 3'd5;
  localparam logic [IDX_W-1:0] REG_OFFSET      = 3'd6;

  localparam logic [SIZE_W-1:0] LINE_LENGTH_RST = 13'd2160;
  localparam logic [SIZE_W-1:0] LINE_COUNT_RST  = 13'd3840;
  localparam logic [47:0]       COEFF_EDGE_RST  = 48'd53673984;
  localparam logic [47:0]       COEFF_MID_RST   = 48'd3517631890227;
  localparam logic [15:0]       GAIN_RST        = 16'd256;
  localparam logic [9:0]        OFFSET_RST      = 10'd0;

  localparam logic [2:0] SLOT_COPY0 = 3'd3;
  localparam logic [2:0] SLOT_COPY1 = 3'd4;

  typedef enum logic {OP_PIXEL = 1'b0, OP_DRAIN = 1'b1} op_t;

  typedef struct packed {
    logic [47:0] coeff_prev;
    logic [47:0] coeff_same;
    logic [47:0] coeff_next;
    logic [15:0] gain;
    logic [9:0]  offset;
  } cfg_t;

  typedef struct packed {
    logic [2:0]           s_prev;
    logic [2:0]           s_same;
    logic [2:0]           s_next;
    logic [11:0]          line;
    logic [JOB_COL_W-1:0] col;
    logic                 run_last;
    logic                 frame_done;
  } job_t;

  typedef struct packed {
    logic                 en;
    logic [2:0]           slot;
    logic [JOB_COL_W-1:0] col;
    logic [23:0]          pixel;
  } store_wr_t;

  function automatic int clamp_size(int v, int hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

endpackage

// ===== src/wcv_front.sv =====
// Front end: accepts items, tracks raster position, writes the line store
// and queues convolution jobs. Depends on wcv_pkg.
module wcv_front #(
  parameter int MAX_LINE_LENGTH = wcv_pkg::MAX_LINE_LENGTH_DEF,
  parameter int MAX_LINE_COUNT  = wcv_pkg::MAX_LINE_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [23:0]               in_tdata,
  input  logic                      in_tuser,
  input  logic [$clog2(MAX_LINE_LENGTH+1)-1:0] len,
  input  logic [$clog2(MAX_LINE_COUNT+1)-1:0]  cnt,
  input  logic                      q_empty,
  input  logic                      back_busy,
  output wcv_pkg::store_wr_t        wr,
  output wcv_pkg::job_t             jobs [3],
  output logic [1:0]                push_n
);

  localparam int LEN_W = $clog2(MAX_LINE_LENGTH+1);
  localparam int COL_W = $clog2(MAX_LINE_LENGTH);
  localparam int CNT_W = $clog2(MAX_LINE_COUNT+1);
  localparam int LIN_W = $clog2(MAX_LINE_COUNT);
  localparam int POS_W = LEN_W + 1;

  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [LIN_W-1:0] in_line_r, in_line_nxt;
  logic [1:0]       head_r, head_nxt;
  logic [POS_W-1:0] drain_pos_r, drain_pos_nxt;
  logic             draining_r, draining_nxt;
  logic             pend_r, pend_nxt;
  logic [2:0]       pend_slot_r, pend_slot_nxt;
  logic [COL_W-1:0] pend_col_r, pend_col_nxt;
  logic [23:0]      pend_px_r, pend_px_nxt;

  logic             accept;
  wcv_pkg::op_t     op;
  logic [LEN_W-1:0] len_m1;
  logic [CNT_W-1:0] cnt_m1;
  logic [COL_W-1:0] col;
  logic [LIN_W-1:0] line;
  logic             col_last, line_last;
  logic [1:0]       head, sp, ss;
  logic [POS_W-1:0] pos_max, pos;
  logic [11:0]      line_prev;

  function automatic logic [1:0] inc3(logic [1:0] h);
    case (h)
      2'd0:    return 2'd1;
      2'd1:    return 2'd2;
      default: return 2'd0;
    endcase
  endfunction

  assign in_tready = !back_busy && q_empty && !pend_r;
  assign accept    = in_tvalid && in_tready;
  assign op        = wcv_pkg::op_t'(in_tuser);
  assign len_m1    = len - LEN_W'(1);
  assign cnt_m1    = cnt - CNT_W'(1);
  assign col       = (LEN_W'(in_col_r) > len_m1) ? COL_W'(len_m1) : in_col_r;
  assign line      = (CNT_W'(in_line_r) > cnt_m1) ? LIN_W'(cnt_m1) : in_line_r;
  assign col_last  = LEN_W'(col) == len_m1;
  assign line_last = CNT_W'(line) == cnt_m1;
  assign head      = (head_r == 2'd3) ? 2'd0 : head_r;
  assign sp        = inc3(head);
  assign ss        = inc3(sp);
  assign pos_max   = {len, 1'b0} - POS_W'(1);
  assign pos       = (drain_pos_r > pos_max) ? pos_max : drain_pos_r;
  assign line_prev = 12'(LIN_W'(line - LIN_W'(1)));

  always_comb begin
    in_col_nxt    = in_col_r;
    in_line_nxt   = in_line_r;
    head_nxt      = head_r;
    drain_pos_nxt = drain_pos_r;
    draining_nxt  = draining_r;
    pend_nxt      = 1'b0;
    pend_slot_nxt = pend_slot_r;
    pend_col_nxt  = pend_col_r;
    pend_px_nxt   = pend_px_r;
    push_n        = 2'd0;
    wr.en         = pend_r;
    wr.slot       = pend_slot_r;
    wr.col        = wcv_pkg::JOB_COL_W'(pend_col_r);
    wr.pixel      = pend_px_r;
    for (int i = 0; i < 3; i++) begin
      jobs[i].s_prev     = {1'b0, sp};
      jobs[i].s_same     = {1'b0, ss};
      jobs[i].s_next     = {1'b0, head};
      jobs[i].line       = line_prev;
      jobs[i].col        = '0;
      jobs[i].run_last   = 1'b0;
      jobs[i].frame_done = 1'b0;
    end
    jobs[0].col = wcv_pkg::JOB_COL_W'(COL_W'(col - COL_W'(1)));
    jobs[1].col = wcv_pkg::JOB_COL_W'(col);
    jobs[2].run_last = 1'b1;

    if (accept && op == wcv_pkg::OP_DRAIN && draining_r) begin
      push_n = 2'd1;
      jobs[0].run_last = 1'b1;
      if (pos < POS_W'(len)) begin
        jobs[0].s_prev = {1'b0, ss};
        jobs[0].s_same = {1'b0, head};
        jobs[0].s_next = wcv_pkg::SLOT_COPY0;
        jobs[0].line   = 12'(cnt_m1);
        jobs[0].col    = wcv_pkg::JOB_COL_W'(pos);
      end else begin
        jobs[0].s_prev = {1'b0, head};
        jobs[0].s_same = wcv_pkg::SLOT_COPY0;
        jobs[0].s_next = wcv_pkg::SLOT_COPY1;
        jobs[0].line   = 12'd0;
        jobs[0].col    = wcv_pkg::JOB_COL_W'(pos - POS_W'(len));
      end
      if (pos == pos_max) begin
        jobs[0].frame_done = 1'b1;
        draining_nxt       = 1'b0;
        drain_pos_nxt      = '0;
      end else begin
        drain_pos_nxt = pos + POS_W'(1);
      end
    end else if (accept && op == wcv_pkg::OP_PIXEL && !draining_r) begin
      wr.en    = 1'b1;
      wr.slot  = {1'b0, head};
      wr.col   = wcv_pkg::JOB_COL_W'(col);
      wr.pixel = in_tdata;
      pend_slot_nxt = (line == '0) ? wcv_pkg::SLOT_COPY0 : wcv_pkg::SLOT_COPY1;
      pend_col_nxt  = col;
      pend_px_nxt   = in_tdata;
      pend_nxt      = (line == '0) || (line == LIN_W'(1));
      if (CNT_W'(line) >= CNT_W'(2) && LEN_W'(col) >= LEN_W'(2)) begin
        if (col_last) begin
          push_n = 2'd3;
        end else begin
          push_n = 2'd1;
          jobs[0].run_last = 1'b1;
        end
      end
      if (col_last) begin
        in_col_nxt = '0;
        if (line_last) begin
          draining_nxt  = 1'b1;
          drain_pos_nxt = '0;
          in_line_nxt   = '0;
          head_nxt      = head;
        end else begin
          in_line_nxt = line + LIN_W'(1);
          head_nxt    = sp;
        end
      end else begin
        in_col_nxt = col + COL_W'(1);
        head_nxt   = head;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r    <= '0;
      in_line_r   <= '0;
      head_r      <= '0;
      drain_pos_r <= '0;
      draining_r  <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      in_col_r    <= in_col_nxt;
      in_line_r   <= in_line_nxt;
      head_r      <= head_nxt;
      drain_pos_r <= drain_pos_nxt;
      draining_r  <= draining_nxt;
      pend_r      <= pend_nxt;
    end
    pend_slot_r <= pend_slot_nxt;
    pend_col_r  <= pend_col_nxt;
    pend_px_r   <= pend_px_nxt;
  end

endmodule

// ===== src/wcv_queue.sv =====
// Four-entry job queue between front and back end; takes up to three
// jobs per cycle, gives one. Depends on wcv_pkg.
module wcv_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  wcv_pkg::job_t jobs [3],
  input  logic [1:0]    push_n,
  input  logic          pop,
  output logic          q_valid,
  output logic          q_empty,
  output wcv_pkg::job_t q_job
);

  wcv_pkg::job_t ent_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign q_empty = cnt_r == 3'd0;
  assign q_valid = !q_empty;
  assign q_job   = ent_r[rp_r];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_n) ent_r[wp_r + 2'(i)] <= jobs[i];
    end
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + push_n;
      rp_r  <= rp_r + 2'(pop);
      cnt_r <= cnt_r + 3'(push_n) - 3'(pop);
    end
  end

endmodule

// ===== src/wcv_back.sv =====
// Back end: holds the line store, reads the nine taps of a job one per
// cycle, accumulates, scales, clamps and drives the result register.
// Depends on wcv_pkg and wrapped_convolution_3x3_rgb_macros.svh.
`include "wrapped_convolution_3x3_rgb_macros.svh"
module wcv_back #(
  parameter int MAX_LINE_LENGTH = wcv_pkg::MAX_LINE_LENGTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  wcv_pkg::cfg_t             cfg,
  input  logic [$clog2(MAX_LINE_LENGTH+1)-1:0] len,
  input  wcv_pkg::store_wr_t        wr,
  input  logic                      q_valid,
  input  wcv_pkg::job_t             q_job,
  output logic                      q_pop,
  output logic                      back_busy,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [47:0]               out_tdata,   // line, column, red, green, blue
  output logic                      out_tlast,   // run_last
  output logic                      out_tuser    // frame_done
);

  localparam int LEN_W = $clog2(MAX_LINE_LENGTH+1);
  localparam int COL_W = $clog2(MAX_LINE_LENGTH);
  localparam int DEPTH = 5 * MAX_LINE_LENGTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int ACC_W = 28;
  localparam int SCL_W = 44;
  localparam int V_W   = 45;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_SCALE, S_CLAMP} state_t;

  logic [23:0] mem [DEPTH];
  logic [23:0] rdata_r;

  state_t        state_r;
  wcv_pkg::job_t job_r;
  logic [1:0]    row_r, k_r, row1_r, k1_r;
  logic          iss_done_r, v1_r, v2_r, last2_r;
  logic signed [24:0]      prod_r [3];
  logic signed [ACC_W-1:0] acc_r  [3];
  logic signed [SCL_W-1:0] scl_r  [3];
  logic          out_valid_r, out_last_r, out_done_r;
  logic [11:0]   out_line_r, out_col_r;
  logic [7:0]    out_px_r [3];

  logic             rd_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [COL_W-1:0] jc, cm, cp, csel;
  logic [2:0]       ssel;
  logic signed [15:0] tap;
  logic signed [V_W-1:0] v [3];
  logic [7:0]       sat [3];
  logic             load;

  assign jc   = job_r.col[COL_W-1:0];
  assign cm   = (jc == '0) ? COL_W'(len - LEN_W'(1)) : jc - COL_W'(1);
  assign cp   = (LEN_W'(jc) + LEN_W'(1) >= len) ? '0 : jc + COL_W'(1);

  always_comb begin
    case (k_r)
      2'd0:    csel = cm;
      2'd1:    csel = jc;
      default: csel = cp;
    endcase
    case (row_r)
      2'd0:    ssel = job_r.s_prev;
      2'd1:    ssel = job_r.s_same;
      default: ssel = job_r.s_next;
    endcase
  end

  function automatic logic [15:0] pick(logic [47:0] c, logic [1:0] k);
    case (k)
      2'd0:    return c[15:0];
      2'd1:    return c[31:16];
      default: return c[47:32];
    endcase
  endfunction

  always_comb begin
    case (row1_r)
      2'd0:    tap = $signed(pick(cfg.coeff_prev, k1_r));
      2'd1:    tap = $signed(pick(cfg.coeff_same, k1_r));
      default: tap = $signed(pick(cfg.coeff_next, k1_r));
    endcase
  end

  assign rd_en   = state_r == S_RUN && !iss_done_r;
  assign rd_addr = AW'(int'(ssel) * MAX_LINE_LENGTH + int'(csel));
  assign wr_addr = AW'(int'(wr.slot) * MAX_LINE_LENGTH + int'(wr.col[COL_W-1:0]));

  always_ff @(posedge clk) begin
    if (wr.en) mem[wr_addr] <= wr.pixel;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      v[c] = V_W'(scl_r[c]) + (V_W'($signed(cfg.offset)) <<< 20);
      if (v[c][V_W-1]) sat[c] = 8'd0;
      else if (v[c][V_W-2:20] > (V_W-21)'(255)) sat[c] = 8'd255;
      else sat[c] = v[c][27:20];
    end
  end

  assign q_pop     = state_r == S_IDLE && q_valid;
  assign back_busy = state_r != S_IDLE;
  assign load      = state_r == S_CLAMP && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_done_r  <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= rd_en;
      v2_r <= v1_r;
      if (load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            state_r    <= S_RUN;
            iss_done_r <= 1'b0;
          end
        end
        S_RUN: begin
          if (row_r == 2'd2 && k_r == 2'd2) iss_done_r <= 1'b1;
          if (v2_r && last2_r) state_r <= S_SCALE;
        end
        S_SCALE: state_r <= S_CLAMP;
        S_CLAMP: begin
          if (load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
    if (q_pop) begin
      job_r <= q_job;
      row_r <= 2'd0;
      k_r   <= 2'd0;
      for (int c = 0; c < 3; c++) acc_r[c] <= '0;
    end
    if (rd_en) begin
      row1_r <= row_r;
      k1_r   <= k_r;
      if (k_r == 2'd2) begin
        k_r   <= 2'd0;
        row_r <= row_r + 2'd1;
      end else begin
        k_r <= k_r + 2'd1;
      end
    end
    if (v1_r) begin
      last2_r <= row1_r == 2'd2 && k1_r == 2'd2;
      for (int c = 0; c < 3; c++)
        prod_r[c] <= 25'(tap) * $signed({1'b0, rdata_r[8*c +: 8]});
    end
    if (v2_r && state_r == S_RUN) begin
      for (int c = 0; c < 3; c++) acc_r[c] <= acc_r[c] + ACC_W'(prod_r[c]);
    end
    if (state_r == S_SCALE) begin
      for (int c = 0; c < 3; c++)
        scl_r[c] <= SCL_W'(acc_r[c]) * SCL_W'($signed(cfg.gain));
    end
    if (load) begin
      out_line_r <= job_r.line;
      out_col_r  <= 12'(job_r.col);
      out_last_r <= job_r.run_last;
      out_done_r <= job_r.frame_done;
      for (int c = 0; c < 3; c++) out_px_r[c] <= sat[c];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_px_r[2], out_px_r[1], out_px_r[0], out_col_r, out_line_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

  `WCV_ASSERT(a_pop_idle, q_pop |-> (state_r == S_IDLE), "job taken while busy")
  `WCV_ASSERT(a_pipe_quiet, (state_r != S_RUN) |-> (!v1_r && !v2_r), "tap pipe active")
  `WCV_ASSERT_NEXT(a_load_shows, load, out_valid_r, "loaded result not shown")
  `WCV_ASSERT_NEXT(a_scale_next, state_r == S_SCALE, state_r == S_CLAMP, "scale step lost")

endmodule

// ===== src/wrapped_convolution_3x3_rgb.sv =====
// Top level of the wrapped 3x3 RGB convolution block: configuration
// registers, size clamping, front end, job queue and back end.
// Depends on wcv_pkg, wcv_front, wcv_queue and wcv_back.
//
// Input items (in_*): tuser 0 carries an RGB pixel in raster order, tuser 1
// asks for one pending pixel of the final lines. Pixels of lines 1 to
// count-2 yield results while the frame streams; once the last pixel is in,
// each drain item yields one pixel of the last line, then of line 0.
// Result items (out_*): position and filtered color; tlast ends the results
// of one input item, tuser marks the last pixel of the frame.
// Each result takes nine line-store reads on the single read port, two
// pipeline stages, scaling and clamping. An item waits for all of its
// results to be computed; pixels of lines 0 and 1 also wait for the copy
// write to the line store. The result register holds while out_tready is
// low and the next item can still enter; the back end waits on a full
// register.
// Reset clears position and queue state and loads the register defaults;
// the line store is not cleared. Configuration writes take effect at once.
module wrapped_convolution_3x3_rgb #(
  parameter int MAX_LINE_LENGTH = wcv_pkg::MAX_LINE_LENGTH_DEF,
  parameter int MAX_LINE_COUNT  = wcv_pkg::MAX_LINE_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [23:0]               in_tdata,   // red_in, green_in, blue_in
  input  logic                      in_tuser,   // operation
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [47:0]               out_tdata,  // line_index, column_index, red, green, blue
  output logic                      out_tlast,  // run_last
  output logic                      out_tuser,  // frame_done
  input  logic                      cfg_we,
  input  logic [wcv_pkg::IDX_W-1:0] cfg_index,
  input  logic [wcv_pkg::REG_W-1:0] cfg_wdata
);

  localparam int LEN_W = $clog2(MAX_LINE_LENGTH+1);
  localparam int CNT_W = $clog2(MAX_LINE_COUNT+1);

  logic [wcv_pkg::SIZE_W-1:0] line_length_r, line_count_r;
  wcv_pkg::cfg_t      cfg_r;
  logic [LEN_W-1:0]   len;
  logic [CNT_W-1:0]   cnt;
  wcv_pkg::store_wr_t wr;
  wcv_pkg::job_t      jobs [3];
  wcv_pkg::job_t      q_job;
  logic [1:0]         push_n;
  logic               q_valid, q_empty, q_pop, back_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r    <= wcv_pkg::LINE_LENGTH_RST;
      line_count_r     <= wcv_pkg::LINE_COUNT_RST;
      cfg_r.coeff_prev <= wcv_pkg::COEFF_EDGE_RST;
      cfg_r.coeff_same <= wcv_pkg::COEFF_MID_RST;
      cfg_r.coeff_next <= wcv_pkg::COEFF_EDGE_RST;
      cfg_r.gain       <= wcv_pkg::GAIN_RST;
      cfg_r.offset     <= wcv_pkg::OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wcv_pkg::REG_LINE_LENGTH: line_length_r    <= cfg_wdata[wcv_pkg::SIZE_W-1:0];
        wcv_pkg::REG_LINE_COUNT:  line_count_r     <= cfg_wdata[wcv_pkg::SIZE_W-1:0];
        wcv_pkg::REG_COEFF_PREV:  cfg_r.coeff_prev <= cfg_wdata;
        wcv_pkg::REG_COEFF_SAME:  cfg_r.coeff_same <= cfg_wdata;
        wcv_pkg::REG_COEFF_NEXT:  cfg_r.coeff_next <= cfg_wdata;
        wcv_pkg::REG_GAIN:        cfg_r.gain       <= cfg_wdata[15:0];
        wcv_pkg::REG_OFFSET:      cfg_r.offset     <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  assign len = LEN_W'(wcv_pkg::clamp_size(int'(line_length_r), MAX_LINE_LENGTH));
  assign cnt = CNT_W'(wcv_pkg::clamp_size(int'(line_count_r), MAX_LINE_COUNT));

  wcv_front #(
    .MAX_LINE_LENGTH(MAX_LINE_LENGTH),
    .MAX_LINE_COUNT (MAX_LINE_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .len      (len),
    .cnt      (cnt),
    .q_empty  (q_empty),
    .back_busy(back_busy),
    .wr       (wr),
    .jobs     (jobs),
    .push_n   (push_n)
  );

  wcv_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .jobs   (jobs),
    .push_n (push_n),
    .pop    (q_pop),
    .q_valid(q_valid),
    .q_empty(q_empty),
    .q_job  (q_job)
  );

  wcv_back #(
    .MAX_LINE_LENGTH(MAX_LINE_LENGTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .len       (len),
    .wr        (wr),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_pop     (q_pop),
    .back_busy (back_busy),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule
